[hdl/piecewise_poly_derivative_eval_macros.svh]
// Assertion macros for the evaluator RTL.
`ifndef PIECEWISE_POLY_DERIVATIVE_EVAL_MACROS_SVH
`define PIECEWISE_POLY_DERIVATIVE_EVAL_MACROS_SVH

`ifndef SYNTH

// Condition implies consequence in the same cycle.
`define PPDE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition implies consequence in the next cycle.
`define PPDE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PPDE_ASSERT_IMP(lbl, ante, cons, msg)
`define PPDE_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

[hdl/ppde_pkg.sv]
package ppde_pkg;

    // Store geometry
    localparam int SEGMENTS = 64;
    localparam int COEFFS   = 8;
    localparam int AXES     = 3;
    localparam int ORDERS   = 8;

    localparam int SEG_AW    = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
    localparam int CI_AW     = $clog2(COEFFS);
    localparam int MEM_AW    = SEG_AW + CI_AW;
    localparam int MEM_DEPTH = SEGMENTS * (2 ** CI_AW);

    // Field widths
    localparam int SEG_W   = 6;
    localparam int AX_W    = 2;
    localparam int CI_W    = 3;
    localparam int COEF_W  = 32;
    localparam int TIME_W  = 24;
    localparam int ORD_W   = 3;
    localparam int ACC_W   = 48;
    localparam int HALF_W  = ACC_W / 2;
    localparam int FRAC_W  = 16;

    // Falling factorial width, enough for sixteen coefficients and order seven
    localparam int FACT_W  = 28;
    localparam int PH_W    = HALF_W + TIME_W;
    localparam int PROD_W  = ACC_W + TIME_W;
    localparam int SHR_W   = PROD_W - FRAC_W;
    localparam int CF_W    = COEF_W + FACT_W + 1;
    localparam int SUM_W   = ((SHR_W > CF_W) ? SHR_W : CF_W) + 1;

    // Action codes
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EVAL = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_ACC,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic start;
        logic mul;
        logic sum;
        logic acc;
        logic step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic skip;
        logic last;
        logic out_free;
    } t_status;

    typedef logic [COEFFS-1:0][ORDERS-1:0][FACT_W-1:0] t_fact_tab;

    // Falling factorial p*(p-1)*...*(p-d+1) by coefficient position and order
    function automatic t_fact_tab build_fact_tab();
        t_fact_tab tab;
        int p;
        int f;
        for (int i = 0; i < COEFFS; i++) begin
            p = COEFFS - 1 - i;
            for (int d = 0; d < ORDERS; d++) begin
                f = 1;
                if (p < d) begin
                    f = 0;
                end else begin
                    for (int r = 0; r < d; r++) begin
                        f = f * (p - r);
                    end
                end
                tab[i][d] = FACT_W'(f);
            end
        end
        return tab;
    endfunction

    localparam t_fact_tab FACT_TAB = build_fact_tab();

endpackage

[hdl/ppde_ctrl.sv]
module ppde_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic               i_action,
    input  ppde_pkg::t_status  i_status,
    output ppde_pkg::t_cmd     o_cmd
);

    ppde_pkg::t_state r_state;
    ppde_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ppde_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Accept words, sequence each term through multiply, combine, accumulate, then hand off the result
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            ppde_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    if (i_action == ppde_pkg::ACT_EVAL) begin
                        o_cmd.start = 1'b1;
                        n_state     = i_status.skip ? ppde_pkg::ST_DONE : ppde_pkg::ST_MUL;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            ppde_pkg::ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ppde_pkg::ST_SUM;
            end
            ppde_pkg::ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = ppde_pkg::ST_ACC;
            end
            ppde_pkg::ST_ACC: begin
                o_cmd.acc = 1'b1;
                if (i_status.last) begin
                    n_state = ppde_pkg::ST_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = ppde_pkg::ST_MUL;
                end
            end
            ppde_pkg::ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ppde_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ppde_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[hdl/ppde_datapath.sv]
module ppde_datapath (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  ppde_pkg::t_cmd                         i_cmd,
    output ppde_pkg::t_status                      o_status,
    input  logic [ppde_pkg::SEG_W-1:0]             i_segment,
    input  logic [ppde_pkg::AX_W-1:0]              i_axis,
    input  logic [ppde_pkg::CI_W-1:0]              i_coeff_index,
    input  logic signed [ppde_pkg::COEF_W-1:0]     i_coeff_value,
    input  logic [ppde_pkg::TIME_W-1:0]            i_time_q,
    input  logic [ppde_pkg::ORD_W-1:0]             i_deriv_order,
    input  logic                                   i_m_tready,
    output logic                                   o_m_tvalid,
    output logic signed [ppde_pkg::ACC_W-1:0]      o_value_x,
    output logic signed [ppde_pkg::ACC_W-1:0]      o_value_y,
    output logic signed [ppde_pkg::ACC_W-1:0]      o_value_z,
    output logic                                   o_saturated
);

    localparam int AXES   = ppde_pkg::AXES;
    localparam int ACC_W  = ppde_pkg::ACC_W;
    localparam int HALF_W = ppde_pkg::HALF_W;
    localparam int SUM_W  = ppde_pkg::SUM_W;

    // Coefficient store, one memory per axis
    logic [ppde_pkg::COEF_W-1:0] r_mem [AXES][ppde_pkg::MEM_DEPTH];
    logic [ppde_pkg::COEF_W-1:0] r_rd  [AXES];

    // Evaluate context
    logic [ppde_pkg::SEG_AW-1:0] r_seg;
    logic [ppde_pkg::CI_AW-1:0]  r_idx;
    logic [ppde_pkg::CI_AW-1:0]  r_last;
    logic [ppde_pkg::ORD_W-1:0]  r_d;
    logic [ppde_pkg::TIME_W-1:0] r_t;

    // Per-axis arithmetic
    logic [2*HALF_W-1:0]                r_pl   [AXES];
    logic signed [ppde_pkg::PH_W-1:0]   r_ph   [AXES];
    logic signed [ppde_pkg::CF_W-1:0]   r_cf   [AXES];
    logic signed [ppde_pkg::PROD_W-1:0] r_prod [AXES];
    logic signed [ACC_W-1:0]            r_acc  [AXES];
    logic [AXES-1:0]                    r_sat;

    logic [2*HALF_W-1:0]                pl_full [AXES];
    logic signed [ppde_pkg::PH_W:0]     ph_full [AXES];
    logic signed [ppde_pkg::CF_W-1:0]   cf_full [AXES];
    logic signed [ppde_pkg::PROD_W-1:0] prod_full [AXES];
    logic signed [SUM_W-1:0]            sum_full [AXES];
    logic signed [ACC_W-1:0]            acc_next [AXES];
    logic [AXES-1:0]                    sat_next;

    // Output register
    logic                    r_out_valid;
    logic signed [ACC_W-1:0] r_out_val [AXES];
    logic                    r_out_sat;

    logic                       wr_ok;
    logic [ppde_pkg::MEM_AW-1:0] waddr;
    logic [ppde_pkg::MEM_AW-1:0] raddr;
    logic                       rd_en;
    logic [ppde_pkg::FACT_W-1:0] fact;

    // Decode load target and read address
    assign wr_ok = (int'(i_axis) < AXES) && (int'(i_coeff_index) < ppde_pkg::COEFFS)
                   && (int'(i_segment) < ppde_pkg::SEGMENTS);
    assign waddr = {ppde_pkg::SEG_AW'(i_segment), ppde_pkg::CI_AW'(i_coeff_index)};
    assign rd_en = i_cmd.start | i_cmd.step;
    assign raddr = i_cmd.start ? {ppde_pkg::SEG_AW'(i_segment), ppde_pkg::CI_AW'(0)}
                               : {r_seg, r_idx + ppde_pkg::CI_AW'(1)};
    assign fact  = ppde_pkg::FACT_TAB[r_idx][r_d];

    // Status toward the controller
    assign o_status.skip     = (int'(i_deriv_order) >= ppde_pkg::COEFFS)
                               || (int'(i_segment) >= ppde_pkg::SEGMENTS);
    assign o_status.last     = (r_idx == r_last);
    assign o_status.out_free = !r_out_valid || i_m_tready;

    // Write and read the store
    always_ff @(posedge i_clk) begin
        for (int a = 0; a < AXES; a++) begin
            if (i_cmd.load && wr_ok && (i_axis == ppde_pkg::AX_W'(a))) begin
                r_mem[a][waddr] <= i_coeff_value;
            end
            if (rd_en) begin
                r_rd[a] <= r_mem[a][raddr];
            end
        end
    end

    // Latch evaluate context, advance the term index
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_seg  <= ppde_pkg::SEG_AW'(i_segment);
            r_idx  <= '0;
            r_last <= ppde_pkg::CI_AW'(ppde_pkg::COEFFS - 1 - int'(i_deriv_order));
            r_d    <= i_deriv_order;
            r_t    <= i_time_q;
        end else if (i_cmd.step) begin
            r_idx  <= r_idx + ppde_pkg::CI_AW'(1);
        end
    end

    // Partial products, combine, floor shift, add term and clamp
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            pl_full[a]   = r_acc[a][HALF_W-1:0] * r_t;
            ph_full[a]   = $signed(r_acc[a][ACC_W-1:HALF_W]) * $signed({1'b0, r_t});
            cf_full[a]   = $signed(r_rd[a]) * $signed({1'b0, fact});
            prod_full[a] = $signed({r_ph[a], {HALF_W{1'b0}}})
                           + $signed({{HALF_W{1'b0}}, r_pl[a]});
            sum_full[a]  = SUM_W'($signed(r_prod[a][ppde_pkg::PROD_W-1:ppde_pkg::FRAC_W]))
                           + SUM_W'(r_cf[a]);
            acc_next[a]  = sum_full[a][ACC_W-1:0];
            sat_next[a]  = 1'b0;
            if (!sum_full[a][SUM_W-1] && (|sum_full[a][SUM_W-2:ACC_W-1])) begin
                acc_next[a] = {1'b0, {(ACC_W-1){1'b1}}};
                sat_next[a] = 1'b1;
            end else if (sum_full[a][SUM_W-1] && !(&sum_full[a][SUM_W-2:ACC_W-1])) begin
                acc_next[a] = {1'b1, {(ACC_W-1){1'b0}}};
                sat_next[a] = 1'b1;
            end
        end
    end

    // Per-axis pipeline registers
    always_ff @(posedge i_clk) begin
        for (int a = 0; a < AXES; a++) begin
            if (i_cmd.mul) begin
                r_pl[a] <= pl_full[a];
                r_ph[a] <= ph_full[a][ppde_pkg::PH_W-1:0];
                r_cf[a] <= cf_full[a];
            end
            if (i_cmd.sum) begin
                r_prod[a] <= prod_full[a];
            end
            if (i_cmd.start) begin
                r_acc[a] <= '0;
                r_sat[a] <= 1'b0;
            end else if (i_cmd.acc) begin
                r_acc[a] <= acc_next[a];
                r_sat[a] <= r_sat[a] | sat_next[a];
            end
        end
    end

    // Hold the finished word until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            for (int a = 0; a < AXES; a++) begin
                r_out_val[a] <= r_acc[a];
            end
            r_out_sat <= |r_sat;
        end
    end

    assign o_m_tvalid  = r_out_valid;
    assign o_value_x   = r_out_val[0];
    assign o_value_y   = r_out_val[1];
    assign o_value_z   = r_out_val[2];
    assign o_saturated = r_out_sat;

endmodule

[hdl/piecewise_poly_derivative_eval.sv]
// Piecewise polynomial derivative evaluator. Load words (tuser 0) write one Q16.16
// coefficient into the store and complete in the cycle they are accepted. Evaluate
// words (tuser 1) give one output word holding the derivative of the chosen order for
// x, y and z at time t, each a saturated Q32.16 value, with tuser set if any axis
// clipped. One word is worked at a time: an evaluate of order d passes each of its
// 8-d coefficient terms through a multiply, combine and accumulate step, with the
// three axes handled side by side. The finished word waits in an output register,
// so the next input word is taken while it is still unclaimed. Reading a coefficient
// that was never loaded returns an undefined value.
`include "piecewise_poly_derivative_eval_macros.svh"

module piecewise_poly_derivative_eval (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // [5:0] segment, [7:6] axis, [10:8] coeff_index, [42:11] coeff_value,
    // [66:43] time_q, [69:67] deriv_order, [71:70] zero
    input  logic [71:0]  i_s_tdata,
    // [0] action
    input  logic         i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // [47:0] value_x, [95:48] value_y, [143:96] value_z
    output logic [143:0] o_m_tdata,
    // [0] saturated
    output logic         o_m_tuser
);

    ppde_pkg::t_cmd    cmd;
    ppde_pkg::t_status status;

    logic signed [ppde_pkg::ACC_W-1:0] value_x;
    logic signed [ppde_pkg::ACC_W-1:0] value_y;
    logic signed [ppde_pkg::ACC_W-1:0] value_z;

    // Sequencer
    ppde_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_action   (i_s_tuser),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Store and arithmetic
    ppde_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_segment     (i_s_tdata[5:0]),
        .i_axis        (i_s_tdata[7:6]),
        .i_coeff_index (i_s_tdata[10:8]),
        .i_coeff_value ($signed(i_s_tdata[42:11])),
        .i_time_q      (i_s_tdata[66:43]),
        .i_deriv_order (i_s_tdata[69:67]),
        .i_m_tready    (i_m_tready),
        .o_m_tvalid    (o_m_tvalid),
        .o_value_x     (value_x),
        .o_value_y     (value_y),
        .o_value_z     (value_z),
        .o_saturated   (o_m_tuser)
    );

    assign o_m_tdata = {value_z, value_y, value_x};

    // Checks on the sequencing
    `PPDE_ASSERT_IMP(a_valid_from_load, $rose(o_m_tvalid), $past(cmd.out_load), "output valid rose without a load")
    `PPDE_ASSERT_NXT(a_mul_then_sum, cmd.mul, cmd.sum, "multiply not followed by combine")
    `PPDE_ASSERT_NXT(a_sum_then_acc, cmd.sum, cmd.acc, "combine not followed by accumulate")
    `PPDE_ASSERT_NXT(a_load_sets_valid, cmd.out_load, o_m_tvalid, "output load did not raise valid")

endmodule
